// ===== src/fttc_pkg.sv =====
// shared types and constants of the fan temperature table control block
`default_nettype none

package fttc_pkg;

   localparam int LINES_PER_ZONE_DEF = 5;
   localparam int NUM_FANS = 4;
   localparam int LEVEL_W = 8;
   localparam int TEMP_W = 8;
   localparam int FLAG_W = 5;
   localparam int LINE_IDX_W = 3;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   localparam int LINE_EN_BIT = 0;
   localparam int FAN0_SEL_BIT = 1;
   localparam int FAN1_SEL_BIT = 2;
   localparam int FAN2_SEL_BIT = 3;
   localparam int FAN3_SEL_BIT = 4;

   localparam logic OP_EVALUATE = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef logic [NUM_FANS-1:0][LEVEL_W-1:0] fan_levels_type;

   typedef struct packed {
      fan_levels_type           level;
      logic [TEMP_W-1:0]        high;
      logic [TEMP_W-1:0]        low;
      logic [FLAG_W-1:0]        flags;
   } line_type;

   typedef struct packed {
      logic                     check;
      logic [TEMP_W-1:0]        temp;
   } cmp_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } seq_state_type;

endpackage

`default_nettype wire

// ===== src/fttc_rule_table.sv =====
// rule line storage with one write port and one registered read port
`default_nettype none

module fttc_rule_table #(
   parameter int LINES_PER_ZONE = fttc_pkg::LINES_PER_ZONE_DEF,
   localparam int DEPTH = 2 * LINES_PER_ZONE,
   localparam int IW = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [IW-1:0]     wr_addr,
   input  wire fttc_pkg::line_type wr_line,
   input  wire logic              rd_en,
   input  wire logic [IW-1:0]     rd_addr,
   output fttc_pkg::line_type     rd_line
);
   import fttc_pkg::*;

   logic     en_ff [DEPTH];
   line_type body_ff [DEPTH];
   line_type rd_line_ff;
   line_type rd_line_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            en_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         en_ff[wr_addr] <= wr_line.flags[LINE_EN_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         body_ff[wr_addr] <= wr_line;
      end
   end

   always_comb begin
      rd_line_in = body_ff[rd_addr];
      rd_line_in.flags[LINE_EN_BIT] = en_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_line_ff <= rd_line_in;
      end
   end

   assign rd_line = rd_line_ff;

endmodule

`default_nettype wire

// ===== src/fttc_fan_bank.sv =====
// shared window compare unit and the fan level and enable registers
`default_nettype none

module fttc_fan_bank (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fttc_pkg::cmp_req_type  cmp_req,
   input  wire fttc_pkg::line_type     line,
   output logic                        hit,
   output fttc_pkg::fan_levels_type    fan_level,
   output logic [fttc_pkg::NUM_FANS-1:0] fan_on
);
   import fttc_pkg::*;

   fan_levels_type       level_ff;
   fan_levels_type       level_in;
   logic [NUM_FANS-1:0]  on_ff;
   logic [NUM_FANS-1:0]  on_in;

   always_comb begin
      hit = cmp_req.check && line.flags[LINE_EN_BIT]
            && (cmp_req.temp >= line.low) && (cmp_req.temp <= line.high);
      level_in = level_ff;
      on_in = on_ff;
      if (hit) begin
         for (int f = 0; f < NUM_FANS; f++) begin
            if (line.flags[FAN0_SEL_BIT + f]) begin
               level_in[f] = line.level[f];
               on_in[f] = |line.level[f];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         on_ff <= '0;
      end else begin
         level_ff <= level_in;
         on_ff <= on_in;
      end
   end

   assign fan_level = level_ff;
   assign fan_on = on_ff;

endmodule

`default_nettype wire

// ===== src/fttc_scan_seq.sv =====
// sequencer: input handshake, table scan in priority order, result register
`default_nettype none

module fttc_scan_seq #(
   parameter int LINES_PER_ZONE = fttc_pkg::LINES_PER_ZONE_DEF,
   localparam int DEPTH = 2 * LINES_PER_ZONE,
   localparam int IW = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_op,
   input  wire logic [fttc_pkg::TEMP_W-1:0]   req_zone0_temp,
   input  wire logic [fttc_pkg::TEMP_W-1:0]   req_zone1_temp,
   output logic                               rd_en,
   output logic [IW-1:0]                      rd_addr,
   output fttc_pkg::cmp_req_type              cmp_req,
   input  wire logic                          hit,
   input  wire fttc_pkg::fan_levels_type      fan_level,
   input  wire logic [fttc_pkg::NUM_FANS-1:0] fan_on,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [fttc_pkg::RSP_DATA_W-1:0]    rsp_data
);
   import fttc_pkg::*;

   localparam logic [IW-1:0] ZONE1_BASE = IW'(LINES_PER_ZONE);
   localparam logic [IW-1:0] LAST_ADDR = IW'(DEPTH - 1);

   seq_state_type         state_ff, state_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic                  issue_ff, issue_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_zone_ff, rd_zone_in;
   logic                  rd_last_ff, rd_last_in;
   logic [1:0]            matched_ff, matched_in;
   logic [TEMP_W-1:0]     t0_ff, t0_in;
   logic [TEMP_W-1:0]     t1_ff, t1_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  hit0;
   logic                  hit1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         matched_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         rd_vld_ff <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         matched_ff <= matched_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rd_zone_ff <= rd_zone_in;
      rd_last_ff <= rd_last_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      issue_in = issue_ff;
      rd_vld_in = 1'b0;
      rd_zone_in = rd_zone_ff;
      rd_last_in = rd_last_ff;
      matched_in = matched_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      req_ready = 1'b0;

      cmp_req.check = (state_ff == ST_SCAN) && rd_vld_ff && !matched_ff[rd_zone_ff];
      cmp_req.temp = rd_zone_ff ? t1_ff : t0_ff;
      hit0 = hit && !rd_zone_ff;
      hit1 = hit && rd_zone_ff;

      // a zone 0 match skips the rest of zone 0
      rd_addr = (hit0 && (cnt_ff < ZONE1_BASE)) ? ZONE1_BASE : cnt_ff;
      rd_en = (state_ff == ST_SCAN) && issue_ff && !hit1;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               matched_in = '0;
               t0_in = req_zone0_temp;
               t1_in = req_zone1_temp;
               if (req_op == OP_EVALUATE) begin
                  cnt_in = '0;
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               matched_in[rd_zone_ff] = 1'b1;
            end
            if (rd_en) begin
               rd_vld_in = 1'b1;
               rd_zone_in = (rd_addr >= ZONE1_BASE);
               rd_last_in = (rd_addr == LAST_ADDR);
               cnt_in = rd_addr + IW'(1);
               if (rd_addr == LAST_ADDR) begin
                  issue_in = 1'b0;
               end
            end
            if (rd_vld_ff && (rd_last_ff || hit1)) begin
               issue_in = 1'b0;
               rd_vld_in = 1'b0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_vld_in = 1'b1;
               rsp_data_in = {2'b00, matched_ff[1], matched_ff[0], fan_on, fan_level};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

// ===== src/fan_temperature_table_control_core.sv =====
// top level of the fan temperature table control block
// write word: the line is stored at acceptance if line_index < LINES_PER_ZONE
// evaluate word: the table is scanned with one table line read and one window compare
// per cycle in priority order, and the result goes out through the rsp register
// one word at a time: req_tready is high only while idle; a result may wait in rsp
// and then stalls the input
// synchronous reset clears every line enable, the fan levels and the fan enable mask
`default_nettype none

module fan_temperature_table_control_core #(
   parameter int LINES_PER_ZONE = fttc_pkg::LINES_PER_ZONE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // zone_select, line_index, line_flags, line_low_temp, line_high_temp,
   // line_level_fan0..line_level_fan3, zone0_temp, zone1_temp, zero fill
   input  wire logic [fttc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // fan0_level..fan3_level, fan_on_mask, zone0_matched, zone1_matched, zero fill
   output logic [fttc_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import fttc_pkg::*;

   localparam int DEPTH = 2 * LINES_PER_ZONE;
   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] ZONE1_BASE = IW'(LINES_PER_ZONE);

   logic                  zone_select;
   logic [LINE_IDX_W-1:0] line_index;
   line_type              wr_line;
   logic [TEMP_W-1:0]     zone0_temp;
   logic [TEMP_W-1:0]     zone1_temp;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic                  rd_en;
   logic [IW-1:0]         rd_addr;
   line_type              rd_line;
   cmp_req_type           cmp_req;
   logic                  hit;
   fan_levels_type        fan_level;
   logic [NUM_FANS-1:0]   fan_on;

   assign zone_select = req_tdata[0];
   assign line_index = req_tdata[3:1];
   assign wr_line.flags = req_tdata[8:4];
   assign wr_line.low = req_tdata[16:9];
   assign wr_line.high = req_tdata[24:17];
   assign wr_line.level[0] = req_tdata[32:25];
   assign wr_line.level[1] = req_tdata[40:33];
   assign wr_line.level[2] = req_tdata[48:41];
   assign wr_line.level[3] = req_tdata[56:49];
   assign zone0_temp = req_tdata[64:57];
   assign zone1_temp = req_tdata[72:65];

   assign wr_en = req_tvalid && req_tready && (req_tuser == OP_WRITE)
                  && (int'(line_index) < LINES_PER_ZONE);
   assign wr_addr = IW'(line_index) + (zone_select ? ZONE1_BASE : IW'(0));

   fttc_rule_table #(
      .LINES_PER_ZONE(LINES_PER_ZONE)
   ) u_rule_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_line (wr_line),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_line (rd_line)
   );

   fttc_fan_bank u_fan_bank (
      .clock     (clock),
      .reset     (reset),
      .cmp_req   (cmp_req),
      .line      (rd_line),
      .hit       (hit),
      .fan_level (fan_level),
      .fan_on    (fan_on)
   );

   fttc_scan_seq #(
      .LINES_PER_ZONE(LINES_PER_ZONE)
   ) u_scan_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_op         (req_tuser),
      .req_zone0_temp (zone0_temp),
      .req_zone1_temp (zone1_temp),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .cmp_req        (cmp_req),
      .hit            (hit),
      .fan_level      (fan_level),
      .fan_on         (fan_on),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_data       (rsp_tdata)
   );

endmodule

`default_nettype wire
